/* rtl/tws_pkg.sv */
package tws_pkg;

  localparam int unsigned ADDR_W    = 7;
  localparam int unsigned DATA_W    = 8;
  localparam int unsigned SHIFT_W   = 16;
  localparam int unsigned COUNT_W   = 5;
  localparam int unsigned HALF_W    = 8;
  localparam int unsigned WAIT_W    = 10;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DAT_W = 10;

  localparam logic [COUNT_W-1:0] BITS_WRITE = 5'd16;
  localparam logic [COUNT_W-1:0] BITS_BYTE  = 5'd8;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BYTE_GAP    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURNAROUND  = 2'd2;

  localparam logic [HALF_W-1:0] HALF_RESET = 8'd1;
  localparam logic [WAIT_W-1:0] GAP_RESET  = 10'd4;
  localparam logic [WAIT_W-1:0] TURN_RESET = 10'd5;

  localparam logic REQ_WRITE = 1'b1;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_SEND_LOW  = 3'd1,
    PH_SEND_HIGH = 3'd2,
    PH_GAP       = 3'd3,
    PH_TURN      = 3'd4,
    PH_RECV_LOW  = 3'd5,
    PH_RECV_HIGH = 3'd6
  } phase_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period;
    logic [WAIT_W-1:0] byte_gap;
    logic [WAIT_W-1:0] turnaround;
  } cfg_t;

  typedef struct packed {
    logic              cs_n;
    logic              sclk;
    logic              sdio_out;
    logic              sdio_oe;
    logic              busy;
    logic              done;
    logic [DATA_W-1:0] read_data;
  } pins_t;

endpackage

/* rtl/tws_seq.sv */
module tws_seq #(
  parameter int unsigned DELAY_BITS = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  tws_pkg::cfg_t                cfg,
  input  logic                         start_req,
  input  logic                         req_type,
  input  logic [tws_pkg::ADDR_W-1:0]   target_addr,
  input  logic [tws_pkg::DATA_W-1:0]   write_data,
  input  logic                         sdio_in,
  output tws_pkg::pins_t               pins_nxt
);

  localparam logic [16:0] LIM = 17'((18'(1) << DELAY_BITS) - 18'(1));

  tws_pkg::phase_t                   ph_r, ph_nxt;
  logic [tws_pkg::COUNT_W-1:0]       bc_r, bc_nxt;
  logic [DELAY_BITS-1:0]             dc_r, dc_nxt;
  logic [tws_pkg::SHIFT_W-1:0]       ss_r, ss_nxt;
  logic [tws_pkg::DATA_W-1:0]        rs_r, rs_nxt;
  logic                              wr_r, wr_nxt;

  logic [tws_pkg::HALF_W-1:0] half_raw;
  logic [16:0]                half_w, gap_w, turn_w;
  logic [DELAY_BITS-1:0]      half_len, gap_len, turn_len;

  always_comb begin
    half_raw = (cfg.half_period == '0) ? tws_pkg::HALF_W'(1) : cfg.half_period;
    half_w   = ({9'b0, half_raw} > LIM) ? LIM : {9'b0, half_raw};
    gap_w    = ({7'b0, cfg.byte_gap} > LIM) ? LIM : {7'b0, cfg.byte_gap};
    turn_w   = ({7'b0, cfg.turnaround} > LIM) ? LIM : {7'b0, cfg.turnaround};
    half_len = half_w[DELAY_BITS-1:0];
    gap_len  = gap_w[DELAY_BITS-1:0];
    turn_len = turn_w[DELAY_BITS-1:0];
  end

  logic done;
  logic gap_go, ab_go, turn_go, recv_go;

  always_comb begin
    ph_nxt  = ph_r;
    bc_nxt  = bc_r;
    dc_nxt  = dc_r;
    ss_nxt  = ss_r;
    rs_nxt  = rs_r;
    wr_nxt  = wr_r;
    done    = 1'b0;
    gap_go  = 1'b0;
    ab_go   = 1'b0;
    turn_go = 1'b0;
    recv_go = 1'b0;
    if (!(ph_r inside {[tws_pkg::PH_SEND_LOW:tws_pkg::PH_RECV_HIGH]})) begin
      ph_nxt = tws_pkg::PH_IDLE;
      if (start_req) begin
        wr_nxt = req_type;
        if (req_type == tws_pkg::REQ_WRITE) begin
          ss_nxt = {1'b1, target_addr, write_data};
          bc_nxt = tws_pkg::BITS_WRITE;
        end else begin
          ss_nxt = {9'b0, target_addr};
          bc_nxt = tws_pkg::BITS_BYTE;
        end
        ph_nxt = tws_pkg::PH_SEND_LOW;
        dc_nxt = half_len;
      end
    end else if (dc_r > DELAY_BITS'(1)) begin
      dc_nxt = dc_r - DELAY_BITS'(1);
    end else begin
      case (ph_r)
        tws_pkg::PH_SEND_LOW: begin
          ph_nxt = tws_pkg::PH_SEND_HIGH;
          dc_nxt = half_len;
        end
        tws_pkg::PH_SEND_HIGH: begin
          if (bc_r != '0) bc_nxt = bc_r - tws_pkg::COUNT_W'(1);
          if (bc_nxt[2:0] == 3'd0) begin
            gap_go = 1'b1;
          end else begin
            ph_nxt = tws_pkg::PH_SEND_LOW;
            dc_nxt = half_len;
          end
        end
        tws_pkg::PH_GAP:  ab_go = 1'b1;
        tws_pkg::PH_TURN: recv_go = 1'b1;
        tws_pkg::PH_RECV_LOW: begin
          rs_nxt = {rs_r[tws_pkg::DATA_W-2:0], sdio_in};
          ph_nxt = tws_pkg::PH_RECV_HIGH;
          dc_nxt = half_len;
        end
        tws_pkg::PH_RECV_HIGH: begin
          if (bc_r != '0) bc_nxt = bc_r - tws_pkg::COUNT_W'(1);
          if (bc_nxt == '0) begin
            ph_nxt = tws_pkg::PH_IDLE;
            dc_nxt = '0;
            done   = 1'b1;
          end else begin
            ph_nxt = tws_pkg::PH_RECV_LOW;
            dc_nxt = half_len;
          end
        end
        default: ph_nxt = tws_pkg::PH_IDLE;
      endcase
    end

    if (gap_go) begin
      if (gap_len == '0) begin
        ab_go = 1'b1;
      end else begin
        ph_nxt = tws_pkg::PH_GAP;
        dc_nxt = gap_len;
      end
    end
    if (ab_go) begin
      if (bc_nxt != '0) begin
        ph_nxt = tws_pkg::PH_SEND_LOW;
        dc_nxt = half_len;
      end else if (wr_r) begin
        ph_nxt = tws_pkg::PH_IDLE;
        dc_nxt = '0;
        done   = 1'b1;
      end else begin
        turn_go = 1'b1;
      end
    end
    if (turn_go) begin
      if (turn_len == '0) begin
        recv_go = 1'b1;
      end else begin
        ph_nxt = tws_pkg::PH_TURN;
        dc_nxt = turn_len;
      end
    end
    if (recv_go) begin
      bc_nxt = tws_pkg::BITS_BYTE;
      ph_nxt = tws_pkg::PH_RECV_LOW;
      dc_nxt = half_len;
    end
  end

  logic [tws_pkg::COUNT_W-1:0] bc_m1;

  always_comb begin
    bc_m1              = bc_nxt - tws_pkg::COUNT_W'(1);
    pins_nxt.cs_n      = (ph_nxt == tws_pkg::PH_IDLE);
    pins_nxt.busy      = (ph_nxt != tws_pkg::PH_IDLE);
    pins_nxt.done      = done;
    pins_nxt.read_data = rs_nxt;
    pins_nxt.sclk      = !(ph_nxt == tws_pkg::PH_SEND_LOW || ph_nxt == tws_pkg::PH_RECV_LOW);
    pins_nxt.sdio_oe   = (ph_nxt inside {tws_pkg::PH_SEND_LOW, tws_pkg::PH_SEND_HIGH,
                                         tws_pkg::PH_GAP, tws_pkg::PH_TURN});
    pins_nxt.sdio_out  = 1'b0;
    case (ph_nxt)
      tws_pkg::PH_SEND_LOW, tws_pkg::PH_SEND_HIGH: begin
        if (bc_nxt >= 5'd1 && bc_nxt <= 5'd16) pins_nxt.sdio_out = ss_nxt[bc_m1[3:0]];
      end
      tws_pkg::PH_GAP, tws_pkg::PH_TURN: begin
        if (bc_nxt < 5'd16) pins_nxt.sdio_out = ss_nxt[bc_nxt[3:0]];
      end
      default: pins_nxt.sdio_out = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= tws_pkg::PH_IDLE;
      bc_r <= '0;
      dc_r <= '0;
      ss_r <= '0;
      rs_r <= '0;
      wr_r <= 1'b0;
    end else if (adv) begin
      ph_r <= ph_nxt;
      bc_r <= bc_nxt;
      dc_r <= dc_nxt;
      ss_r <= ss_nxt;
      rs_r <= rs_nxt;
      wr_r <= wr_nxt;
    end
  end

endmodule

/* rtl/three_wire_serial_register_master_core.sv */
// Three-wire half-duplex serial register master.
// Each input transaction is one timing tick: it carries the access request
// (start_req, req_type, target_addr, write_data) and the sampled data pin level.
// Each tick yields exactly one output transaction with the pin levels after
// that tick (cs_n, sclk, sdio_out, sdio_oe), busy_res, a one-tick done_res
// pulse and the receive byte in read_data.
// Both channels are valid/ready. The sequencer state and an output register
// advance together on each accepted tick, so the result appears in the cycle
// after acceptance and one tick is taken every cycle while the receiver keeps
// up. When out_ready is low the output register holds its transaction and
// in_ready drops; a new tick is taken in the same cycle the held one leaves.
// Configuration (half period, byte gap, turnaround) is written through cfg_we,
// cfg_index and cfg_wdata; the user does so only while no access is in progress (not enforced).
// After a synchronous reset (rst_n low) the sequencer is idle, the output
// register is empty and the configuration holds 1, 4 and 5 ticks.
module three_wire_serial_register_master_core #(
  parameter int unsigned DELAY_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_start_req,
  input  logic                            in_req_type,
  input  logic [tws_pkg::ADDR_W-1:0]      in_target_addr,
  input  logic [tws_pkg::DATA_W-1:0]      in_write_data,
  input  logic                            in_sdio_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            out_cs_n,
  output logic                            out_sclk,
  output logic                            out_sdio_out,
  output logic                            out_sdio_oe,
  output logic                            out_busy_res,
  output logic                            out_done_res,
  output logic [tws_pkg::DATA_W-1:0]      out_read_data,
  input  logic                            cfg_we,
  input  logic [tws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tws_pkg::CFG_DAT_W-1:0]   cfg_wdata
);

  tws_pkg::cfg_t  cfg_r;
  tws_pkg::pins_t pins_nxt, pins_r;
  logic           out_valid_r, out_valid_nxt;
  logic           adv;

  assign in_ready = !out_valid_r || out_ready;
  assign adv      = in_valid && in_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= tws_pkg::HALF_RESET;
      cfg_r.byte_gap    <= tws_pkg::GAP_RESET;
      cfg_r.turnaround  <= tws_pkg::TURN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tws_pkg::CFG_HALF_PERIOD: cfg_r.half_period <= cfg_wdata[tws_pkg::HALF_W-1:0];
        tws_pkg::CFG_BYTE_GAP:    cfg_r.byte_gap    <= cfg_wdata;
        tws_pkg::CFG_TURNAROUND:  cfg_r.turnaround  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tws_seq #(
    .DELAY_BITS(DELAY_BITS)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .cfg        (cfg_r),
    .start_req  (in_start_req),
    .req_type   (in_req_type),
    .target_addr(in_target_addr),
    .write_data (in_write_data),
    .sdio_in    (in_sdio_in),
    .pins_nxt   (pins_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) pins_r <= pins_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_cs_n      = pins_r.cs_n;
  assign out_sclk      = pins_r.sclk;
  assign out_sdio_out  = pins_r.sdio_out;
  assign out_sdio_oe   = pins_r.sdio_oe;
  assign out_busy_res  = pins_r.busy;
  assign out_done_res  = pins_r.done;
  assign out_read_data = pins_r.read_data;

endmodule

/* tb/sv/tb_three_wire_serial_register_master_core.sv */
`timescale 1ns / 1ps

module tb_three_wire_serial_register_master_core;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam logic REQ_READ = ~tws_pkg::REQ_WRITE;
  localparam logic [tws_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    logic                       start_req;
    logic                       req_type;
    logic [tws_pkg::ADDR_W-1:0] target_addr;
    logic [tws_pkg::DATA_W-1:0] write_data;
    logic                       sdio_in;
  } tick_t;

  class pin_scoreboard;
    logic [tws_pkg::HALF_W-1:0]  half_period;
    logic [tws_pkg::WAIT_W-1:0]  byte_gap;
    logic [tws_pkg::WAIT_W-1:0]  turnaround;
    tws_pkg::phase_t             phase;
    logic [tws_pkg::COUNT_W-1:0] bit_count;
    logic [tws_pkg::WAIT_W-1:0]  delay_count;
    logic [tws_pkg::SHIFT_W-1:0] send_shift;
    logic [tws_pkg::DATA_W-1:0]  receive_shift;
    logic                        is_write;
    tws_pkg::pins_t              expected_pins[$];
    int                          errors;
    int                          results_seen;
    int                          writes_done;
    int                          reads_done;

    function new();
      half_period   = tws_pkg::HALF_RESET;
      byte_gap      = tws_pkg::GAP_RESET;
      turnaround    = tws_pkg::TURN_RESET;
      phase         = tws_pkg::PH_IDLE;
      bit_count     = '0;
      delay_count   = '0;
      send_shift    = '0;
      receive_shift = '0;
      is_write      = 1'b0;
      errors        = 0;
      results_seen  = 0;
      writes_done   = 0;
      reads_done    = 0;
    endfunction

    function void apply_reg(logic [tws_pkg::CFG_IDX_W-1:0] idx,
                            logic [tws_pkg::CFG_DAT_W-1:0] val);
      case (idx)
        tws_pkg::CFG_HALF_PERIOD: half_period = val[tws_pkg::HALF_W-1:0];
        tws_pkg::CFG_BYTE_GAP:    byte_gap = val[tws_pkg::WAIT_W-1:0];
        tws_pkg::CFG_TURNAROUND:  turnaround = val[tws_pkg::WAIT_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [tws_pkg::WAIT_W-1:0] half_len();
      return (half_period == '0) ? tws_pkg::WAIT_W'(1) : tws_pkg::WAIT_W'(half_period);
    endfunction

    function void enter(tws_pkg::phase_t p, logic [tws_pkg::WAIT_W-1:0] len);
      phase       = p;
      delay_count = len;
    endfunction

    function void enter_recv();
      bit_count = tws_pkg::BITS_BYTE;
      enter(tws_pkg::PH_RECV_LOW, half_len());
    endfunction

    function void enter_turn();
      if (turnaround == '0) enter_recv();
      else enter(tws_pkg::PH_TURN, turnaround);
    endfunction

    function logic after_byte();
      if (bit_count != '0) begin
        enter(tws_pkg::PH_SEND_LOW, half_len());
        return 1'b0;
      end
      if (is_write) begin
        enter(tws_pkg::PH_IDLE, '0);
        return 1'b1;
      end
      enter_turn();
      return 1'b0;
    endfunction

    function logic enter_gap();
      if (byte_gap == '0) return after_byte();
      enter(tws_pkg::PH_GAP, byte_gap);
      return 1'b0;
    endfunction

    function void predict_tick(tick_t t);
      logic                        done_now;
      logic                        last;
      logic [tws_pkg::COUNT_W-1:0] below;
      tws_pkg::pins_t              want;
      done_now = 1'b0;
      last     = (delay_count <= tws_pkg::WAIT_W'(1));
      if (phase == tws_pkg::PH_IDLE) begin
        if (t.start_req) begin
          is_write = t.req_type;
          if (t.req_type == tws_pkg::REQ_WRITE) begin
            send_shift = {1'b1, t.target_addr, t.write_data};
            bit_count  = tws_pkg::BITS_WRITE;
          end else begin
            send_shift = {9'd0, t.target_addr};
            bit_count  = tws_pkg::BITS_BYTE;
          end
          enter(tws_pkg::PH_SEND_LOW, half_len());
        end
      end else if (!last) begin
        delay_count = delay_count - tws_pkg::WAIT_W'(1);
      end else begin
        case (phase)
          tws_pkg::PH_SEND_LOW: enter(tws_pkg::PH_SEND_HIGH, half_len());
          tws_pkg::PH_SEND_HIGH: begin
            if (bit_count != '0) bit_count = bit_count - tws_pkg::COUNT_W'(1);
            if (bit_count[2:0] == 3'd0) done_now = enter_gap();
            else enter(tws_pkg::PH_SEND_LOW, half_len());
          end
          tws_pkg::PH_GAP: done_now = after_byte();
          tws_pkg::PH_TURN: enter_recv();
          tws_pkg::PH_RECV_LOW: begin
            receive_shift = {receive_shift[tws_pkg::DATA_W-2:0], t.sdio_in};
            enter(tws_pkg::PH_RECV_HIGH, half_len());
          end
          tws_pkg::PH_RECV_HIGH: begin
            if (bit_count != '0) bit_count = bit_count - tws_pkg::COUNT_W'(1);
            if (bit_count == '0) begin
              enter(tws_pkg::PH_IDLE, '0);
              done_now = 1'b1;
            end else begin
              enter(tws_pkg::PH_RECV_LOW, half_len());
            end
          end
          default: ;
        endcase
      end
      if (done_now) begin
        if (is_write) writes_done++;
        else reads_done++;
      end

      want           = '0;
      want.cs_n      = (phase == tws_pkg::PH_IDLE);
      want.sclk      = !(phase == tws_pkg::PH_SEND_LOW || phase == tws_pkg::PH_RECV_LOW);
      want.sdio_oe   = (phase == tws_pkg::PH_SEND_LOW || phase == tws_pkg::PH_SEND_HIGH ||
                        phase == tws_pkg::PH_GAP || phase == tws_pkg::PH_TURN);
      below          = bit_count - tws_pkg::COUNT_W'(1);
      case (phase)
        tws_pkg::PH_SEND_LOW, tws_pkg::PH_SEND_HIGH: begin
          if (bit_count >= 5'd1 && bit_count <= 5'd16)
            want.sdio_out = send_shift[below[3:0]];
        end
        tws_pkg::PH_GAP, tws_pkg::PH_TURN: begin
          if (bit_count < 5'd16) want.sdio_out = send_shift[bit_count[3:0]];
        end
        default: ;
      endcase
      want.busy      = !want.cs_n;
      want.done      = done_now;
      want.read_data = receive_shift;
      expected_pins.push_back(want);
    endfunction

    task report(string what, int unsigned want_v, int unsigned got_v);
      errors++;
      $display("MISMATCH at result %0d: %s expected %0h got %0h",
               results_seen, what, want_v, got_v);
    endtask

    task check_pins(tws_pkg::pins_t got);
      tws_pkg::pins_t want;
      results_seen++;
      if (expected_pins.size() == 0) begin
        report("result with no pending tick, pins", 0, 32'(got));
        return;
      end
      want = expected_pins.pop_front();
      if (got.cs_n !== want.cs_n) report("cs_n", 32'(want.cs_n), 32'(got.cs_n));
      if (got.sclk !== want.sclk) report("sclk", 32'(want.sclk), 32'(got.sclk));
      if (got.sdio_out !== want.sdio_out)
        report("sdio_out", 32'(want.sdio_out), 32'(got.sdio_out));
      if (got.sdio_oe !== want.sdio_oe)
        report("sdio_oe", 32'(want.sdio_oe), 32'(got.sdio_oe));
      if (got.busy !== want.busy) report("busy_res", 32'(want.busy), 32'(got.busy));
      if (got.done !== want.done) report("done_res", 32'(want.done), 32'(got.done));
      if (got.read_data !== want.read_data)
        report("read_data", 32'(want.read_data), 32'(got.read_data));
    endtask

    task close_out();
      if (expected_pins.size() != 0)
        report("results never delivered, count", 32'(expected_pins.size()), 0);
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic                          in_start_req;
  logic                          in_req_type;
  logic [tws_pkg::ADDR_W-1:0]    in_target_addr;
  logic [tws_pkg::DATA_W-1:0]    in_write_data;
  logic                          in_sdio_in;
  logic                          out_valid;
  logic                          out_ready;
  logic                          out_cs_n;
  logic                          out_sclk;
  logic                          out_sdio_out;
  logic                          out_sdio_oe;
  logic                          out_busy_res;
  logic                          out_done_res;
  logic [tws_pkg::DATA_W-1:0]    out_read_data;
  logic                          cfg_we;
  logic [tws_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [tws_pkg::CFG_DAT_W-1:0] cfg_wdata;

  pin_scoreboard  pins_sb;
  tws_pkg::pins_t seen;
  int             burst_left = 0;
  int             ticks_sent = 0;
  int             random_ticks = 0;
  int             settings_used = 1;
  bit             hold_req = 1'b0;
  int             hold_len = 0;

  three_wire_serial_register_master_core u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_start_req  (in_start_req),
    .in_req_type   (in_req_type),
    .in_target_addr(in_target_addr),
    .in_write_data (in_write_data),
    .in_sdio_in    (in_sdio_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_cs_n      (out_cs_n),
    .out_sclk      (out_sclk),
    .out_sdio_out  (out_sdio_out),
    .out_sdio_oe   (out_sdio_oe),
    .out_busy_res  (out_busy_res),
    .out_done_res  (out_done_res),
    .out_read_data (out_read_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen.cs_n      = out_cs_n;
      seen.sclk      = out_sclk;
      seen.sdio_out  = out_sdio_out;
      seen.sdio_oe   = out_sdio_oe;
      seen.busy      = out_busy_res;
      seen.done      = out_done_res;
      seen.read_data = out_read_data;
      pins_sb.check_pins(seen);
    end
  end

  initial begin : watchdog
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles with %0d results outstanding",
             CYCLE_LIMIT, pins_sb.expected_pins.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin : receiver
    int mode;
    int mode_left;
    int run_left;
    bit run_on;
    bit hold_taken;
    mode       = 0;
    mode_left  = 0;
    run_left   = 0;
    run_on     = 1'b0;
    hold_taken = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(50, 300);
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 9) < 7);
          default: begin
            if (run_left == 0) begin
              run_on   = !run_on;
              run_left = run_on ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            run_left--;
            out_ready <= run_on;
          end
        endcase
      end
    end
  end

  function automatic logic [tws_pkg::ADDR_W-1:0] pick_addr();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return tws_pkg::ADDR_W'($urandom);
    endcase
  endfunction

  function automatic logic [tws_pkg::DATA_W-1:0] pick_data();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      default: return tws_pkg::DATA_W'($urandom);
    endcase
  endfunction

  task send_tick(tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_start_req   <= t.start_req;
    in_req_type    <= t.req_type;
    in_target_addr <= t.target_addr;
    in_write_data  <= t.write_data;
    in_sdio_in     <= t.sdio_in;
    do @(posedge clk); while (!in_ready);
    pins_sb.predict_tick(t);
    ticks_sent++;
    @(negedge clk);
  endtask

  task quiet_tick();
    tick_t t;
    t.start_req   = 1'b0;
    t.req_type    = 1'($urandom);
    t.target_addr = pick_addr();
    t.write_data  = pick_data();
    t.sdio_in     = 1'($urandom);
    send_tick(t);
  endtask

  task random_tick();
    tick_t t;
    t.sdio_in     = 1'($urandom);
    t.req_type    = 1'($urandom);
    t.target_addr = pick_addr();
    t.write_data  = pick_data();
    if (pins_sb.phase == tws_pkg::PH_IDLE) t.start_req = ($urandom_range(0, 9) < 7);
    else t.start_req = ($urandom_range(0, 9) == 0);
    send_tick(t);
    random_ticks++;
  endtask

  // hammer: keep start high on every tick of the access, done tick included
  task run_access(logic wr, logic [tws_pkg::ADDR_W-1:0] addr,
                  logic [tws_pkg::DATA_W-1:0] data, bit hammer);
    tick_t t;
    t.start_req   = 1'b1;
    t.req_type    = wr;
    t.target_addr = addr;
    t.write_data  = data;
    t.sdio_in     = 1'($urandom);
    send_tick(t);
    while (pins_sb.phase != tws_pkg::PH_IDLE) begin
      t.start_req   = hammer;
      t.req_type    = 1'($urandom);
      t.target_addr = pick_addr();
      t.write_data  = pick_data();
      t.sdio_in     = 1'($urandom);
      send_tick(t);
    end
  endtask

  task wait_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (pins_sb.expected_pins.size() != 0);
  endtask

  task write_reg(logic [tws_pkg::CFG_IDX_W-1:0] idx, logic [tws_pkg::CFG_DAT_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    pins_sb.apply_reg(idx, val);
  endtask

  task set_timing(logic [tws_pkg::HALF_W-1:0] half, logic [tws_pkg::WAIT_W-1:0] gap,
                  logic [tws_pkg::WAIT_W-1:0] turn);
    while (pins_sb.phase != tws_pkg::PH_IDLE) quiet_tick();
    wait_results();
    write_reg(tws_pkg::CFG_HALF_PERIOD, tws_pkg::CFG_DAT_W'(half));
    write_reg(tws_pkg::CFG_BYTE_GAP, gap);
    write_reg(tws_pkg::CFG_TURNAROUND, turn);
    settings_used++;
  endtask

  initial begin : stimulus
    int                         phase_no;
    int                         len;
    logic [tws_pkg::HALF_W-1:0] half;
    logic [tws_pkg::WAIT_W-1:0] gap;
    logic [tws_pkg::WAIT_W-1:0] turn;
    pins_sb        = new();
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_start_req   = 1'b0;
    in_req_type    = 1'b0;
    in_target_addr = '0;
    in_write_data  = '0;
    in_sdio_in     = 1'b0;
    cfg_we         = 1'b0;
    cfg_index      = '0;
    cfg_wdata      = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    run_access(tws_pkg::REQ_WRITE, 7'h7F, 8'hFF, 1'b0);
    run_access(tws_pkg::REQ_WRITE, 7'h00, 8'h00, 1'b1);
    run_access(REQ_READ, 7'h7F, 8'h00, 1'b1);
    run_access(REQ_READ, 7'h00, 8'hFF, 1'b0);
    repeat (3) quiet_tick();

    set_timing(8'd1, 10'd0, 10'd0);
    run_access(tws_pkg::REQ_WRITE, 7'h55, 8'hA5, 1'b1);
    run_access(REQ_READ, 7'h2A, 8'h5A, 1'b0);

    set_timing(8'd0, 10'd1, 10'd1);
    run_access(tws_pkg::REQ_WRITE, 7'h33, 8'hC3, 1'b0);
    run_access(REQ_READ, 7'h4C, 8'h3C, 1'b1);

    wait_results();
    write_reg(CFG_UNUSED, '1);
    run_access(REQ_READ, 7'h11, 8'h00, 1'b0);

    set_timing(8'd4, 10'd20, 10'd25);
    run_access(tws_pkg::REQ_WRITE, 7'h40, 8'h81, 1'b0);
    run_access(REQ_READ, 7'h01, 8'h7E, 1'b1);

    phase_no = 0;
    while (ticks_sent < 1500 || phase_no < 4) begin
      half = tws_pkg::HALF_W'(($urandom_range(0, 4) == 0) ? $urandom_range(1, 12)
                                                          : $urandom_range(1, 3));
      gap  = tws_pkg::WAIT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 30)
                                                          : $urandom_range(0, 5));
      turn = tws_pkg::WAIT_W'(($urandom_range(0, 4) == 0) ? $urandom_range(0, 30)
                                                          : $urandom_range(0, 5));
      set_timing(half, gap, turn);
      if (phase_no == 1) begin
        hold_len = 300;
        hold_req = 1'b1;
      end
      len = $urandom_range(120, 260);
      for (int i = 0; i < len; i++) begin
        if (phase_no == 3 && i == len / 2) wait_results();
        random_tick();
      end
      phase_no++;
    end

    while (pins_sb.phase != tws_pkg::PH_IDLE) quiet_tick();
    wait_results();
    repeat (10) @(negedge clk);
    pins_sb.close_out();

    $display("Ran %0d ticks (%0d random) over %0d timing settings, zero to long waits",
             ticks_sent, random_ticks, settings_used);
    $display("Finished %0d writes and %0d reads, checked %0d results, %0d mismatches",
             pins_sb.writes_done, pins_sb.reads_done, pins_sb.results_seen, pins_sb.errors);
    if (pins_sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
